// ----- src/itp_pkg.sv -----
// Shared types, constants and decode functions for the infix to postfix converter.
`timescale 1ns / 1ps

package itp_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

   localparam logic [7:0] CHAR_OPEN   = 8'h28;  // (
   localparam logic [7:0] CHAR_CLOSE  = 8'h29;  // )
   localparam logic [7:0] CHAR_TIMES  = 8'h2A;  // *
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;  // +
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;  // -
   localparam logic [7:0] CHAR_DIVIDE = 8'h2F;  // /
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_EQUAL  = 8'h3D;

   typedef enum logic [2:0] {
      OP_OPEN   = 3'd0,
      OP_PLUS   = 3'd1,
      OP_MINUS  = 3'd2,
      OP_TIMES  = 3'd3,
      OP_DIVIDE = 3'd4
   } op_code_type;

   typedef enum logic [1:0] {
      KIND_OPERAND,
      KIND_OPEN,
      KIND_CLOSE,
      KIND_OPERATOR
   } char_kind_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_OVERFLOW  = 2'd1,
      ERR_UNMATCHED = 2'd2
   } err_type;

   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_DECODE,
      SEQ_CLOSE_POP,
      SEQ_CLOSE_CHAR,
      SEQ_OP_POP,
      SEQ_OP_SPACE,
      SEQ_FLUSH_POP,
      SEQ_FLUSH_CHAR,
      SEQ_END_EQ
   } seq_state_type;

   typedef struct packed {
      logic        push;
      logic        pop;
      op_code_type code;
   } stk_cmd_type;

   typedef struct packed {
      logic        empty;
      logic        full;
      op_code_type top;
   } stk_stat_type;

   function automatic char_kind_type char_kind(input logic [7:0] ch);
      char_kind_type k;
      case (ch)
         CHAR_OPEN:   k = KIND_OPEN;
         CHAR_CLOSE:  k = KIND_CLOSE;
         CHAR_PLUS:   k = KIND_OPERATOR;
         CHAR_MINUS:  k = KIND_OPERATOR;
         CHAR_TIMES:  k = KIND_OPERATOR;
         CHAR_DIVIDE: k = KIND_OPERATOR;
         default:     k = KIND_OPERAND;
      endcase
      return k;
   endfunction

   function automatic op_code_type char_code(input logic [7:0] ch);
      op_code_type c;
      case (ch)
         CHAR_PLUS:   c = OP_PLUS;
         CHAR_MINUS:  c = OP_MINUS;
         CHAR_TIMES:  c = OP_TIMES;
         CHAR_DIVIDE: c = OP_DIVIDE;
         default:     c = OP_OPEN;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] code_char(input op_code_type c);
      logic [7:0] ch;
      case (c)
         OP_PLUS:   ch = CHAR_PLUS;
         OP_MINUS:  ch = CHAR_MINUS;
         OP_TIMES:  ch = CHAR_TIMES;
         OP_DIVIDE: ch = CHAR_DIVIDE;
         default:   ch = CHAR_OPEN;
      endcase
      return ch;
   endfunction

   function automatic logic [1:0] code_prio(input op_code_type c);
      logic [1:0] p;
      case (c)
         OP_PLUS:   p = 2'd2;
         OP_MINUS:  p = 2'd2;
         OP_TIMES:  p = 2'd3;
         OP_DIVIDE: p = 2'd3;
         default:   p = 2'd1;
      endcase
      return p;
   endfunction

endpackage

// ----- src/infix_to_postfix_converter.sv -----
// Top level of the shunting-yard infix to postfix converter.
// Operands are emitted and open parentheses pushed when decoded; operators, close parentheses
// and the end item pop and emit stack entries in turn, one stack step per cycle while the
// output is not stalled.
// Output stalls hold the sequencer; no character is taken until the previous one is done.
// Synchronous reset empties the stack and clears the error status; entries are not cleared.
`timescale 1ns / 1ps

module infix_to_postfix_converter (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_char
   input  logic       req_tlast,   // end_of_expr
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic       rsp_tlast,   // last_byte
   output logic [1:0] rsp_tuser    // [1:0] status
);

   itp_pkg::stk_cmd_type  stk_cmd;
   itp_pkg::stk_stat_type stk_stat;

   itp_stack u_stack (
      .clock (clock),
      .reset (reset),
      .cmd   (stk_cmd),
      .stat  (stk_stat)
   );

   itp_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .stk_cmd    (stk_cmd),
      .stk_stat   (stk_stat)
   );

endmodule

// ----- src/itp_stack.sv -----
// Operator stack: register file with a fill count, top entry read at the count minus one.
`timescale 1ns / 1ps

module itp_stack (
   input  logic                 clock,
   input  logic                 reset,
   input  itp_pkg::stk_cmd_type cmd,
   output itp_pkg::stk_stat_type stat
);

   itp_pkg::op_code_type           stack_ff [itp_pkg::STACK_DEPTH];
   logic [itp_pkg::CNT_W-1:0]      count_ff;
   logic [itp_pkg::CNT_W-1:0]      count_in;
   logic [itp_pkg::CNT_W-1:0]      count_dec;
   logic [itp_pkg::PTR_W-1:0]      top_ptr;
   logic [itp_pkg::PTR_W-1:0]      wr_ptr;
   logic                           full;
   logic                           empty;

   assign full      = (count_ff == itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH));
   assign empty     = (count_ff == '0);
   assign count_dec = count_ff - itp_pkg::CNT_W'(1);
   assign top_ptr   = count_dec[itp_pkg::PTR_W-1:0];
   assign wr_ptr    = count_ff[itp_pkg::PTR_W-1:0];

   always_comb begin
      count_in = count_ff;
      if (cmd.push && !full) begin
         count_in = count_ff + itp_pkg::CNT_W'(1);
      end else if (cmd.pop && !empty) begin
         count_in = count_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // drop a push onto a full stack
   always_ff @(posedge clock) begin
      if (cmd.push && !full) begin
         stack_ff[wr_ptr] <= cmd.code;
      end
   end

   assign stat.empty = empty;
   assign stat.full  = full;
   assign stat.top   = stack_ff[top_ptr];

endmodule

// ----- src/itp_seq.sv -----
// Sequencer: decodes each character, drives stack pops and pushes, emits bytes.
`timescale 1ns / 1ps

module itp_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,
   output logic                  rsp_tlast,
   output logic [1:0]            rsp_tuser,
   output itp_pkg::stk_cmd_type  stk_cmd,
   input  itp_pkg::stk_stat_type stk_stat
);

   itp_pkg::seq_state_type state_ff, state_in;
   itp_pkg::err_type       err_ff, err_in;
   itp_pkg::op_code_type   hold_ff, hold_in;
   itp_pkg::char_kind_type kind;
   itp_pkg::op_code_type   in_code;
   logic [7:0]             char_ff;
   logic                   end_ff;
   logic                   rsp_valid_ff;
   logic [7:0]             rsp_char_ff;
   logic                   rsp_last_ff;
   itp_pkg::err_type       rsp_status_ff;
   logic                   can_emit;
   logic                   emit;
   logic [7:0]             emit_char;
   logic                   emit_last;
   logic                   pop_more;

   assign req_tready = (state_ff == itp_pkg::SEQ_IDLE);
   assign can_emit   = !rsp_valid_ff || rsp_tready;
   assign kind       = itp_pkg::char_kind(char_ff);
   assign in_code    = itp_pkg::char_code(char_ff);
   // the shared compare: does the top of the stack bind at least as tight
   assign pop_more   = !stk_stat.empty &&
                       (itp_pkg::code_prio(stk_stat.top) >= itp_pkg::code_prio(in_code));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         itp_pkg::SEQ_IDLE: begin
            if (req_tvalid) state_in = itp_pkg::SEQ_DECODE;
         end
         itp_pkg::SEQ_DECODE: begin
            if (can_emit) begin
               if (end_ff) begin
                  state_in = itp_pkg::SEQ_FLUSH_POP;
               end else begin
                  case (kind)
                     itp_pkg::KIND_CLOSE:    state_in = itp_pkg::SEQ_CLOSE_POP;
                     itp_pkg::KIND_OPERATOR: state_in = itp_pkg::SEQ_OP_POP;
                     default:                state_in = itp_pkg::SEQ_IDLE;
                  endcase
               end
            end
         end
         itp_pkg::SEQ_CLOSE_POP: begin
            if (can_emit) begin
               if (stk_stat.empty || stk_stat.top == itp_pkg::OP_OPEN) begin
                  state_in = itp_pkg::SEQ_IDLE;
               end else begin
                  state_in = itp_pkg::SEQ_CLOSE_CHAR;
               end
            end
         end
         itp_pkg::SEQ_CLOSE_CHAR: begin
            if (can_emit) state_in = itp_pkg::SEQ_CLOSE_POP;
         end
         itp_pkg::SEQ_OP_POP: begin
            if (can_emit) state_in = pop_more ? itp_pkg::SEQ_OP_SPACE : itp_pkg::SEQ_IDLE;
         end
         itp_pkg::SEQ_OP_SPACE: begin
            if (can_emit) state_in = itp_pkg::SEQ_OP_POP;
         end
         itp_pkg::SEQ_FLUSH_POP: begin
            if (can_emit) begin
               state_in = stk_stat.empty ? itp_pkg::SEQ_END_EQ : itp_pkg::SEQ_FLUSH_CHAR;
            end
         end
         itp_pkg::SEQ_FLUSH_CHAR: begin
            if (can_emit) state_in = itp_pkg::SEQ_FLUSH_POP;
         end
         itp_pkg::SEQ_END_EQ: begin
            if (can_emit) state_in = itp_pkg::SEQ_IDLE;
         end
         default: state_in = itp_pkg::SEQ_IDLE;
      endcase
   end

   always_comb begin
      emit         = 1'b0;
      emit_char    = itp_pkg::CHAR_SPACE;
      emit_last    = 1'b0;
      stk_cmd.push = 1'b0;
      stk_cmd.pop  = 1'b0;
      stk_cmd.code = itp_pkg::OP_OPEN;
      err_in       = err_ff;
      hold_in      = hold_ff;
      if (can_emit) begin
         case (state_ff)
            itp_pkg::SEQ_DECODE: begin
               if (!end_ff) begin
                  case (kind)
                     itp_pkg::KIND_OPERAND: begin
                        emit      = 1'b1;
                        emit_char = char_ff;
                     end
                     itp_pkg::KIND_OPEN: begin
                        stk_cmd.push = 1'b1;
                        stk_cmd.code = itp_pkg::OP_OPEN;
                        if (stk_stat.full && err_ff == itp_pkg::ERR_NONE) begin
                           err_in = itp_pkg::ERR_OVERFLOW;
                        end
                     end
                     itp_pkg::KIND_OPERATOR: begin
                        emit = 1'b1;
                     end
                     default: ;
                  endcase
               end
            end
            itp_pkg::SEQ_CLOSE_POP: begin
               if (stk_stat.empty) begin
                  if (err_ff == itp_pkg::ERR_NONE) err_in = itp_pkg::ERR_UNMATCHED;
               end else begin
                  stk_cmd.pop = 1'b1;
                  hold_in     = stk_stat.top;
                  emit        = (stk_stat.top != itp_pkg::OP_OPEN);
               end
            end
            itp_pkg::SEQ_CLOSE_CHAR, itp_pkg::SEQ_FLUSH_CHAR: begin
               emit      = 1'b1;
               emit_char = itp_pkg::code_char(hold_ff);
            end
            itp_pkg::SEQ_OP_POP: begin
               if (pop_more) begin
                  stk_cmd.pop = 1'b1;
                  emit        = 1'b1;
                  emit_char   = itp_pkg::code_char(stk_stat.top);
               end else begin
                  stk_cmd.push = 1'b1;
                  stk_cmd.code = in_code;
                  if (stk_stat.full && err_ff == itp_pkg::ERR_NONE) begin
                     err_in = itp_pkg::ERR_OVERFLOW;
                  end
               end
            end
            itp_pkg::SEQ_OP_SPACE: begin
               emit = 1'b1;
            end
            itp_pkg::SEQ_FLUSH_POP: begin
               emit = 1'b1;
               if (!stk_stat.empty) begin
                  stk_cmd.pop = 1'b1;
                  hold_in     = stk_stat.top;
               end
            end
            itp_pkg::SEQ_END_EQ: begin
               emit      = 1'b1;
               emit_char = itp_pkg::CHAR_EQUAL;
               emit_last = 1'b1;
               err_in    = itp_pkg::ERR_NONE;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= itp_pkg::SEQ_IDLE;
         err_ff       <= itp_pkg::ERR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         err_ff   <= err_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // status travels with the byte as it stood before this step's update
   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      if (req_tvalid && req_tready) begin
         char_ff <= req_tdata;
         end_ff  <= req_tlast;
      end
      if (emit) begin
         rsp_char_ff   <= emit_char;
         rsp_last_ff   <= emit_last;
         rsp_status_ff <= err_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the infix to postfix converter with a byte-level scoreboard.
`timescale 1ns / 1ps

module testbench;

   localparam int LIMIT_CYCLES = 400000;
   localparam int ITEM_TARGET  = 310;

   class postfix_checker;
      typedef struct packed {
         logic [7:0]       ch;
         logic             last;
         itp_pkg::err_type status;
      } out_byte_type;

      itp_pkg::op_code_type opers[itp_pkg::STACK_DEPTH];
      int unsigned          depth;
      itp_pkg::err_type     err;
      out_byte_type         expected_bytes[$];
      int unsigned          mismatches;

      function new();
         depth      = 0;
         err        = itp_pkg::ERR_NONE;
         mismatches = 0;
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction

      function logic [7:0] op_text(itp_pkg::op_code_type c);
         case (c)
            itp_pkg::OP_PLUS:   return itp_pkg::CHAR_PLUS;
            itp_pkg::OP_MINUS:  return itp_pkg::CHAR_MINUS;
            itp_pkg::OP_TIMES:  return itp_pkg::CHAR_TIMES;
            itp_pkg::OP_DIVIDE: return itp_pkg::CHAR_DIVIDE;
            default:            return itp_pkg::CHAR_OPEN;
         endcase
      endfunction

      function int rank(itp_pkg::op_code_type c);
         if (c == itp_pkg::OP_OPEN) return 1;
         if (c == itp_pkg::OP_PLUS || c == itp_pkg::OP_MINUS) return 2;
         return 3;
      endfunction

      function void emit(logic [7:0] ch, logic last);
         out_byte_type b;
         b.ch     = ch;
         b.last   = last;
         b.status = err;
         expected_bytes.push_back(b);
      endfunction

      function void flag(itp_pkg::err_type e);
         if (err == itp_pkg::ERR_NONE) err = e;
      endfunction

      function void push(itp_pkg::op_code_type c);
         if (depth >= itp_pkg::STACK_DEPTH) flag(itp_pkg::ERR_OVERFLOW);
         else begin
            opers[depth] = c;
            depth++;
         end
      endfunction

      function void apply_operator(itp_pkg::op_code_type c);
         emit(itp_pkg::CHAR_SPACE, 1'b0);
         while (depth > 0 && rank(opers[depth - 1]) >= rank(c)) begin
            depth--;
            emit(op_text(opers[depth]), 1'b0);
            emit(itp_pkg::CHAR_SPACE, 1'b0);
         end
         push(c);
      endfunction

      // Work out the bytes one accepted character produces.
      function void note_char(logic [7:0] ch, logic fin);
         itp_pkg::op_code_type c;
         bit                   done;
         if (fin) begin
            while (depth > 0) begin
               depth--;
               emit(itp_pkg::CHAR_SPACE, 1'b0);
               emit(op_text(opers[depth]), 1'b0);
            end
            emit(itp_pkg::CHAR_SPACE, 1'b0);
            emit(itp_pkg::CHAR_EQUAL, 1'b1);
            err = itp_pkg::ERR_NONE;
         end else begin
            case (ch)
               itp_pkg::CHAR_OPEN:   push(itp_pkg::OP_OPEN);
               itp_pkg::CHAR_PLUS:   apply_operator(itp_pkg::OP_PLUS);
               itp_pkg::CHAR_MINUS:  apply_operator(itp_pkg::OP_MINUS);
               itp_pkg::CHAR_TIMES:  apply_operator(itp_pkg::OP_TIMES);
               itp_pkg::CHAR_DIVIDE: apply_operator(itp_pkg::OP_DIVIDE);
               itp_pkg::CHAR_CLOSE: begin
                  done = 0;
                  while (!done) begin
                     if (depth == 0) begin
                        flag(itp_pkg::ERR_UNMATCHED);
                        done = 1;
                     end else begin
                        depth--;
                        c = opers[depth];
                        if (c == itp_pkg::OP_OPEN) done = 1;
                        else begin
                           emit(itp_pkg::CHAR_SPACE, 1'b0);
                           emit(op_text(c), 1'b0);
                        end
                     end
                  end
               end
               default:     emit(ch, 1'b0);
            endcase
         end
      endfunction

      function void check_byte(logic [7:0] ch, logic last, logic [1:0] status);
         out_byte_type want;
         if (expected_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected byte %02h last %0b status %0d", ch, last, status);
         end else begin
            want = expected_bytes.pop_front();
            if (want.ch !== ch || want.last !== last || want.status !== status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"byte mismatch: expected %02h last %0b status %0d,",
                            " got %02h last %0b status %0d"},
                           want.ch, want.last, want.status, ch, last, status);
            end
         end
      endfunction
   endclass

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic [1:0] rsp_tuser;

   postfix_checker book = new();
   int unsigned    items_sent = 0;
   int unsigned    cycles = 0;
   bit             steady = 0;

   infix_to_postfix_converter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT_CYCLES) begin
         $display("infix_to_postfix_converter verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 22);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         book.check_byte(rsp_tdata, rsp_tlast, rsp_tuser);
   end

   function automatic bit is_special(logic [7:0] b);
      return b inside {itp_pkg::CHAR_OPEN, itp_pkg::CHAR_CLOSE, itp_pkg::CHAR_PLUS,
                       itp_pkg::CHAR_MINUS, itp_pkg::CHAR_TIMES, itp_pkg::CHAR_DIVIDE};
   endfunction

   function automatic logic [7:0] pick_operand();
      logic [7:0] b;
      if ($urandom_range(0, 9) < 7) b = 8'(8'h61 + $urandom_range(0, 25));
      else begin
         do b = 8'($urandom_range(0, 255)); while (is_special(b));
      end
      return b;
   endfunction

   function automatic logic [7:0] pick_operator();
      case ($urandom_range(0, 3))
         0:       return itp_pkg::CHAR_PLUS;
         1:       return itp_pkg::CHAR_MINUS;
         2:       return itp_pkg::CHAR_TIMES;
         default: return itp_pkg::CHAR_DIVIDE;
      endcase
   endfunction

   task automatic send_item(input logic [7:0] ch, input logic fin);
      steady = (items_sent >= 120 && items_sent < 180);
      if (!steady && $urandom_range(0, 99) < 22) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      book.note_char(ch, fin);
      items_sent++;
   endtask

   task automatic send_end();
      send_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   // Hold the sender until every queued byte has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (book.pending() != 0);
   endtask

   task automatic send_expr();
      int mode;
      int terms;
      int nest;
      int k;
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
         repeat ($urandom_range(3, 8)) send_item(8'($urandom_range(0, 255)), 1'b0);
      end else if (mode == 1) begin
         // deep nesting can run into the full stack
         k = $urandom_range(14, 19);
         repeat (k) send_item(itp_pkg::CHAR_OPEN, 1'b0);
         send_item(pick_operand(), 1'b0);
         send_item(pick_operator(), 1'b0);
         send_item(pick_operand(), 1'b0);
         repeat ($urandom_range(k - 1, k + 1)) send_item(itp_pkg::CHAR_CLOSE, 1'b0);
      end else begin
         terms = $urandom_range(1, 6);
         nest  = 0;
         for (int i = 0; i < terms; i++) begin
            while (nest < 6 && $urandom_range(0, 3) == 0) begin
               send_item(itp_pkg::CHAR_OPEN, 1'b0);
               nest++;
            end
            send_item(pick_operand(), 1'b0);
            while (nest > 0 && $urandom_range(0, 2) == 0) begin
               send_item(itp_pkg::CHAR_CLOSE, 1'b0);
               nest--;
            end
            if (i < terms - 1) send_item(pick_operator(), 1'b0);
         end
         // mode 2 leaves the nesting broken
         if (mode == 2) begin
            if ($urandom_range(0, 1)) nest = nest + 1;
            else nest = 0;
         end
         repeat (nest) send_item(itp_pkg::CHAR_CLOSE, 1'b0);
      end
      send_end();
   endtask

   initial begin
      bit drained;
      drained = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // mixed priorities with extreme operand bytes
      send_item(8'h00, 1'b0);
      send_item(itp_pkg::CHAR_PLUS, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(itp_pkg::CHAR_TIMES, 1'b0);
      send_item("c", 1'b0);
      send_item(itp_pkg::CHAR_MINUS, 1'b0);
      send_item(itp_pkg::CHAR_OPEN, 1'b0);
      send_item("d", 1'b0);
      send_item(itp_pkg::CHAR_DIVIDE, 1'b0);
      send_item("e", 1'b0);
      send_item(itp_pkg::CHAR_CLOSE, 1'b0);
      send_item(8'hA5, 1'b1);
      // unmatched close, then a second error that must not overwrite the first
      send_item(itp_pkg::CHAR_CLOSE, 1'b0);
      send_item(itp_pkg::CHAR_CLOSE, 1'b0);
      send_item(8'h5A, 1'b1);
      // leftover open parentheses are flushed as text
      send_item(itp_pkg::CHAR_OPEN, 1'b0);
      send_item(itp_pkg::CHAR_OPEN, 1'b0);
      send_item("x", 1'b0);
      send_item(8'h00, 1'b1);

      while (items_sent < ITEM_TARGET) begin
         send_expr();
         if (!drained && items_sent >= 200) begin
            drain();
            drained = 1;
         end
      end
      req_tvalid <= 1'b0;

      while (book.pending() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (book.mismatches == 0 && book.pending() == 0)
         $display("infix_to_postfix_converter verification clean");
      else
         $display("infix_to_postfix_converter verification failed");
      $finish;
   end

endmodule

// ----- files.f -----
src/itp_pkg.sv
src/itp_stack.sv
src/itp_seq.sv
src/infix_to_postfix_converter.sv
dv/testbench.sv
